[rtl/kps_pkg.sv]
// Package of the Kalman position smoother: fixed-point formats, register
// indexes, the serial-step control type and reset values.
// Depends on nothing; every other file of the block depends on it.
package kps_pkg;

   localparam int FIELD_W = 31;
   localparam int VAR_W = 32;
   localparam int FRAC_BITS = 28;
   localparam int GAIN_W = FRAC_BITS + 1;
   localparam int DEN_W = VAR_W + 1;
   localparam int REM_W = VAR_W + 2;
   localparam int CNT_W = $clog2(GAIN_W);
   localparam int COORD_WIDTH_DEFAULT = 32;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_NOISE = 1'b1;

   localparam logic [VAR_W-1:0] ONE_Q28 = 32'd268435456;
   localparam logic [VAR_W-1:0] Q_RESET = 32'd268435;
   localparam logic [VAR_W-1:0] R_RESET = 32'd26843546;

   typedef struct packed {
      logic load;
      logic step;
   } kps_ctrl_type;

endpackage

[rtl/kps_channel_if.sv]
// Valid/ready channel interfaces for position fixes in and smoothed
// positions out. Depends on kps_pkg for the field width.
interface kps_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [kps_pkg::FIELD_W-1:0] fix_longitude;
   logic signed [kps_pkg::FIELD_W-1:0] fix_latitude;

   modport source (output valid, output fix_longitude, output fix_latitude, input ready);
   modport sink (input valid, input fix_longitude, input fix_latitude, output ready);
endinterface

interface kps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [kps_pkg::FIELD_W-1:0] smooth_longitude;
   logic signed [kps_pkg::FIELD_W-1:0] smooth_latitude;

   modport source (output valid, output smooth_longitude, output smooth_latitude, input ready);
   modport sink (input valid, input smooth_longitude, input smooth_latitude, output ready);
endinterface

[rtl/kps_divider.sv]
// Radix-2 restoring divider that produces the Kalman gain one quotient bit
// per cycle while stepping, most significant bit first. Depends on kps_pkg.
module kps_divider (
   input  logic                      clock,
   input  kps_pkg::kps_ctrl_type     ctrl,
   input  logic [kps_pkg::VAR_W-1:0] numer,
   input  logic [kps_pkg::DEN_W-1:0] denom,
   output logic                      qbit
);
   import kps_pkg::*;

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             zero_ff, zero_in;
   logic [REM_W-1:0] den_ext;
   logic [REM_W-1:0] diff;
   logic [REM_W-1:0] kept;
   logic             ge;

   assign den_ext = {1'b0, den_ff};
   assign ge = rem_ff >= den_ext;
   assign diff = rem_ff - den_ext;
   assign kept = ge ? diff : rem_ff;
   // A zero denominator means a zero gain.
   assign qbit = ge && !zero_ff;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      zero_in = zero_ff;
      if (ctrl.load) begin
         rem_in = {{(REM_W-VAR_W){1'b0}}, numer};
         den_in = denom;
         zero_in = (denom == '0);
      end else if (ctrl.step) begin
         rem_in = {kept[REM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      zero_ff <= zero_in;
   end

endmodule

[rtl/kps_mac.sv]
// Serial multiply lane: accumulates a magnitude times the gain as the gain
// bits arrive most significant first. Depends on kps_pkg.
module kps_mac #(
   parameter int MAG_W = kps_pkg::VAR_W
) (
   input  logic                              clock,
   input  kps_pkg::kps_ctrl_type             ctrl,
   input  logic [MAG_W-1:0]                  mag,
   input  logic                              qbit,
   output logic [MAG_W+kps_pkg::GAIN_W-1:0] product
);
   import kps_pkg::*;

   localparam int ACC_W = MAG_W + GAIN_W;

   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] addend;

   assign addend = qbit ? {{GAIN_W{1'b0}}, mag_ff} : '0;
   assign product = acc_ff;

   always_comb begin
      mag_in = mag_ff;
      acc_in = acc_ff;
      if (ctrl.load) begin
         mag_in = mag;
         acc_in = '0;
      end else if (ctrl.step) begin
         acc_in = {acc_ff[ACC_W-2:0], 1'b0} + addend;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      acc_ff <= acc_in;
   end

endmodule

[rtl/kalman_position_smoother.sv]
// Top level of the Kalman position smoother: control sequencer, estimate
// and variance registers. Depends on kps_pkg, kps_channel_if, kps_divider
// and kps_mac.
//
// The block smooths (longitude, latitude) fixes in signed Q9.22 with a
// scalar-covariance Kalman filter. The first fix after reset only loads the
// estimate and gives no result. Every later fix goes from its transfer to
// its result in the output register through a setup state, a divide state
// in which the radix-2 gain divider hands one gain bit per cycle to three
// serial multiply lanes (longitude, latitude, variance), an update state
// and a state that loads the output register. The next fix is taken once
// the sequencer is back in idle, also while a result still waits in the
// output register. Process and measurement noise are written through the
// csr port; the user must do so only while the block is idle (unenforced).
module kalman_position_smoother #(
   parameter int COORD_WIDTH = kps_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   kps_req_if.sink                         req_bus,
   kps_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [kps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kps_pkg::VAR_W-1:0]       csr_wdata
);
   import kps_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int DW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
   localparam int SW = DW + 2;
   localparam int ACC_W = DW + GAIN_W;
   localparam int VACC_W = VAR_W + GAIN_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_UPD  = 5'b01000,
      ST_OUT  = 5'b10000
   } kps_state_type;

   kps_state_type      state_ff, state_in;
   logic               primed_ff, primed_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VAR_W-1:0]   q_ff, q_in;
   logic [VAR_W-1:0]   r_ff, r_in;
   logic [VAR_W-1:0]   p_ff, p_in;
   logic [VAR_W-1:0]   pp_ff, pp_in;
   logic [FIELD_W-1:0] zlon_ff, zlon_in;
   logic [FIELD_W-1:0] zlat_ff, zlat_in;
   logic [CW-1:0]      est_lon_ff, est_lon_in;
   logic [CW-1:0]      est_lat_ff, est_lat_in;
   logic               neg_lon_ff, neg_lon_in;
   logic               neg_lat_ff, neg_lat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_lon_ff, rsp_lon_in;
   logic [FIELD_W-1:0] rsp_lat_ff, rsp_lat_in;

   kps_ctrl_type       ctrl;
   logic               req_accept;
   logic [VAR_W:0]     pp_sum;
   logic [VAR_W-1:0]   pp_sat;
   logic [DEN_W-1:0]   den;
   logic [DW-1:0]      d_lon, d_lat;
   logic [DW-1:0]      mag_lon, mag_lat;
   logic               qbit;
   logic [ACC_W-1:0]   prod_lon, prod_lat;
   logic [VACC_W-1:0]  prod_var;
   logic [SW-1:0]      step_lon, step_lat;
   logic [SW-1:0]      x_lon, x_lat;
   logic [VAR_W:0]     kp;

   function automatic logic [CW-1:0] sat_coord(input logic [SW-1:0] v);
      logic [SW-1:0] hi;
      logic [SW-1:0] lo;
      logic [CW-1:0] res;
      hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
      lo = ~hi;
      if ($signed(v) > $signed(hi)) begin
         res = hi[CW-1:0];
      end else if ($signed(v) < $signed(lo)) begin
         res = lo[CW-1:0];
      end else begin
         res = v[CW-1:0];
      end
      return res;
   endfunction

   function automatic logic [FIELD_W-1:0] sat_field(input logic [CW-1:0] e);
      logic [SW-1:0]      v;
      logic [SW-1:0]      hi;
      logic [SW-1:0]      lo;
      logic [FIELD_W-1:0] res;
      v = {{(SW-CW){e[CW-1]}}, e};
      hi = {{(SW-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}};
      lo = ~hi;
      if ($signed(v) > $signed(hi)) begin
         res = hi[FIELD_W-1:0];
      end else if ($signed(v) < $signed(lo)) begin
         res = lo[FIELD_W-1:0];
      end else begin
         res = v[FIELD_W-1:0];
      end
      return res;
   endfunction

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.smooth_longitude = rsp_lon_ff;
   assign rsp_bus.smooth_latitude = rsp_lat_ff;

   assign pp_sum = {1'b0, p_ff} + {1'b0, q_ff};
   assign pp_sat = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
   assign den = {1'b0, pp_sat} + {1'b0, r_ff};

   assign d_lon = {{(DW-FIELD_W){zlon_ff[FIELD_W-1]}}, zlon_ff}
                - {{(DW-CW){est_lon_ff[CW-1]}}, est_lon_ff};
   assign d_lat = {{(DW-FIELD_W){zlat_ff[FIELD_W-1]}}, zlat_ff}
                - {{(DW-CW){est_lat_ff[CW-1]}}, est_lat_ff};
   assign mag_lon = d_lon[DW-1] ? (~d_lon + 1'b1) : d_lon;
   assign mag_lat = d_lat[DW-1] ? (~d_lat + 1'b1) : d_lat;

   assign x_lon = {{(SW-CW){est_lon_ff[CW-1]}}, est_lon_ff};
   assign x_lat = {{(SW-CW){est_lat_ff[CW-1]}}, est_lat_ff};
   assign step_lon = {{(SW-(ACC_W-FRAC_BITS)){1'b0}}, prod_lon[ACC_W-1:FRAC_BITS]};
   assign step_lat = {{(SW-(ACC_W-FRAC_BITS)){1'b0}}, prod_lat[ACC_W-1:FRAC_BITS]};
   assign kp = prod_var[VACC_W-1:FRAC_BITS];

   kps_divider u_divider (
      .clock (clock),
      .ctrl  (ctrl),
      .numer (pp_sat),
      .denom (den),
      .qbit  (qbit)
   );

   kps_mac #(.MAG_W(DW)) u_mac_lon (
      .clock   (clock),
      .ctrl    (ctrl),
      .mag     (mag_lon),
      .qbit    (qbit),
      .product (prod_lon)
   );

   kps_mac #(.MAG_W(DW)) u_mac_lat (
      .clock   (clock),
      .ctrl    (ctrl),
      .mag     (mag_lat),
      .qbit    (qbit),
      .product (prod_lat)
   );

   kps_mac #(.MAG_W(VAR_W)) u_mac_var (
      .clock   (clock),
      .ctrl    (ctrl),
      .mag     (pp_sat),
      .qbit    (qbit),
      .product (prod_var)
   );

   always_comb begin
      state_in = state_ff;
      primed_in = primed_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      r_in = r_ff;
      p_in = p_ff;
      pp_in = pp_ff;
      zlon_in = zlon_ff;
      zlat_in = zlat_ff;
      est_lon_in = est_lon_ff;
      est_lat_in = est_lat_ff;
      neg_lon_in = neg_lon_ff;
      neg_lat_in = neg_lat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_lon_in = rsp_lon_ff;
      rsp_lat_in = rsp_lat_ff;
      ctrl = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_PROCESS_NOISE: begin
               q_in = csr_wdata;
            end
            CSR_MEASUREMENT_NOISE: begin
               r_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               zlon_in = req_bus.fix_longitude;
               zlat_in = req_bus.fix_latitude;
               if (!primed_ff) begin
                  est_lon_in = sat_coord({{(SW-FIELD_W){req_bus.fix_longitude[FIELD_W-1]}},
                                          req_bus.fix_longitude});
                  est_lat_in = sat_coord({{(SW-FIELD_W){req_bus.fix_latitude[FIELD_W-1]}},
                                          req_bus.fix_latitude});
                  primed_in = 1'b1;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            ctrl.load = 1'b1;
            pp_in = pp_sat;
            neg_lon_in = d_lon[DW-1];
            neg_lat_in = d_lat[DW-1];
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctrl.step = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_UPD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_UPD: begin
            est_lon_in = sat_coord(neg_lon_ff ? (x_lon - step_lon) : (x_lon + step_lon));
            est_lat_in = sat_coord(neg_lat_ff ? (x_lat - step_lat) : (x_lat + step_lat));
            p_in = pp_ff - kp[VAR_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_lon_in = sat_field(est_lon_ff);
               rsp_lat_in = sat_field(est_lat_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         primed_ff <= 1'b0;
         cnt_ff <= '0;
         q_ff <= Q_RESET;
         r_ff <= R_RESET;
         p_ff <= ONE_Q28;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         primed_ff <= primed_in;
         cnt_ff <= cnt_in;
         q_ff <= q_in;
         r_ff <= r_in;
         p_ff <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pp_ff <= pp_in;
      zlon_ff <= zlon_in;
      zlat_ff <= zlat_in;
      est_lon_ff <= est_lon_in;
      est_lat_ff <= est_lat_in;
      neg_lon_ff <= neg_lon_in;
      neg_lat_ff <= neg_lat_in;
      rsp_lon_ff <= rsp_lon_in;
      rsp_lat_ff <= rsp_lat_in;
   end

endmodule

[rtl/kps_checker.sv]
// Port-level checker for the Kalman position smoother and the bind that
// attaches it to the top level. Depends on kps_pkg.
module kps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [kps_pkg::FIELD_W-1:0] rsp_lon,
   input logic [kps_pkg::FIELD_W-1:0] rsp_lat
);
   import kps_pkg::*;

   // A result that waits must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   // A result that waits must not change.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_lon) && $stable(rsp_lat))
      else $error("result changed before its transfer");

   // A result never follows a fix transfer in the very next cycle.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared right after a fix transfer");

   // Reset leaves the block ready for a fix with no result pending.
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind kalman_position_smoother kps_checker u_kps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_lon   (rsp_bus.smooth_longitude),
   .rsp_lat   (rsp_bus.smooth_latitude)
);
